/* hdl/spi_register_transaction_master_defines.svh */
// Assertion macros shared by the SPI register transaction master RTL.
`ifndef SPI_REGISTER_TRANSACTION_MASTER_DEFINES_SVH
`define SPI_REGISTER_TRANSACTION_MASTER_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define SRTM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define SRTM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/srtm_pkg.sv */
// Types and constants of the SPI register transaction master.
package srtm_pkg;

  // Request kinds carried in s_axis_tuser
  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_START = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  // Frame sequencer phases
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LEAD = 2'd1,
    PH_LOW  = 2'd2,
    PH_HIGH = 2'd3
  } phase_e;

  localparam logic [7:0] READ_FLAG  = 8'h80;
  localparam logic [7:0] ADDR_MASK  = 8'h7f;
  localparam logic [7:0] ABSENT_VAL = 8'hFF;

  // One result item
  typedef struct packed {
    logic       busy_res;
    logic       device_present;
    logic       frame_done;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       mosi_level;
    logic       serial_clock;
    logic       chip_select;
  } res_t;

endpackage

/* hdl/srtm_buf.sv */
// Transmit byte buffer: one write port, one registered read port.
module srtm_buf #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [7:0]    wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [7:0]    rd_data_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_q;
  logic       rd_ok_q;

  // Store loaded bytes
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read every cycle; out-of-range indexes read as zero
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
    rd_ok_q   <= rd_en_i;
  end

  assign rd_data_o = rd_ok_q ? rd_data_q : 8'h00;

endmodule

/* hdl/srtm_skid.sv */
// Two-entry output stage for result items.
module srtm_skid (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  srtm_pkg::res_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output srtm_pkg::res_t out_data_o
);

  logic           out_valid_q, out_valid_d;
  logic           skid_valid_q, skid_valid_d;
  srtm_pkg::res_t out_data_q, skid_data_q;
  logic           out_fire, in_fire, load_out, load_skid;

  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && !skid_valid_q;
  assign out_fire   = out_valid_q && out_ready_i;

  // Steer the incoming request to the output or the skid slot
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    load_out     = 1'b0;
    load_skid    = 1'b0;
    if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_d = 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid_q || out_fire) begin
        load_out    = 1'b1;
        out_valid_d = 1'b1;
      end else begin
        load_skid    = 1'b1;
        skid_valid_d = 1'b1;
      end
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Payload holds without reset
  always_ff @(posedge clk_i) begin
    if (skid_valid_q && out_fire) begin
      out_data_q <= skid_data_q;
    end else if (load_out) begin
      out_data_q <= in_data_i;
    end
    if (load_skid) begin
      skid_data_q <= in_data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* hdl/spi_register_transaction_master.sv */
// Top level of the SPI register transaction master.
//
//  channel | direction | handshake                    | content
//  s_axis  | in        | s_axis_tvalid/s_axis_tready  | load, start or tick request
//  m_axis  | out       | m_axis_tvalid/m_axis_tready  | pin levels and status per request
//  cfg     | in        | cfg_valid_i/cfg_ready_o      | half_period_ticks
//
//  One request is accepted per clock cycle while the output stage has room; its result is registered there.
//  Throughput is set by the sequencer state update and the buffer read
//  port, which prefetches the next data byte while a byte is being shifted.
//  Reset is asynchronous and active low; the byte buffer needs no clearing pass.
//  A two-entry output stage lets requests flow while one result waits;
//  s_axis_tready drops only when both entries hold results.
`include "spi_register_transaction_master_defines.svh"

module spi_register_transaction_master #(
  parameter int MAX_BYTES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // reg_address[6:0], is_read[7], byte_count[11:8], write_byte[19:12], miso_level[20]
  input  logic [23:0] s_axis_tdata,
  // action[1:0]
  input  logic [1:0]  s_axis_tuser,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // chip_select[0], serial_clock[1], mosi_level[2], read_byte[10:3],
  // device_present[11], busy_res[12]
  output logic [15:0] m_axis_tdata,
  // read_valid[0]
  output logic        m_axis_tuser,
  // frame_done
  output logic        m_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  cfg_data_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o
);

  localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int IW = ($clog2(MAX_BYTES + 1) > 4) ? $clog2(MAX_BYTES + 1) : 4;

  // Request fields
  logic [6:0] in_addr;
  logic       in_rd;
  logic [3:0] in_cnt;
  logic [7:0] in_wbyte;
  logic       in_miso;
  logic [1:0] in_act;
  logic       in_fire;

  assign in_addr  = s_axis_tdata[6:0];
  assign in_rd    = s_axis_tdata[7];
  assign in_cnt   = s_axis_tdata[11:8];
  assign in_wbyte = s_axis_tdata[19:12];
  assign in_miso  = s_axis_tdata[20];
  assign in_act   = s_axis_tuser;
  assign in_fire  = s_axis_tvalid && s_axis_tready;

  // State
  srtm_pkg::phase_e phase_q, phase_d;
  logic [7:0] hp_q;
  logic [7:0] tc_q, tc_d;
  logic [2:0] bit_q, bit_d;
  logic [3:0] byte_q, byte_d;
  logic [7:0] shift_q, shift_d;
  logic [6:0] lat_addr_q, lat_addr_d;
  logic       lat_rd_q, lat_rd_d;
  logic [3:0] lat_cnt_q, lat_cnt_d;
  logic       ff_q, ff_d;
  logic       mosi_q, mosi_d;

  // Configuration register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp_q <= 8'd4;
    end else if (cfg_valid_i) begin
      hp_q <= cfg_data_i;
    end
  end

  // Shared sequencer conditions
  logic [7:0] hp_eff, tc_inc;
  logic       is_idle, do_tick, half_end, sending, last_bit, last_byte, do_start;
  logic       ff_now;
  logic [3:0] cnt_clip;

  assign hp_eff    = (hp_q == 8'd0) ? 8'd1 : hp_q;
  assign tc_inc    = tc_q + 8'd1;
  assign is_idle   = (phase_q == srtm_pkg::PH_IDLE);
  assign do_tick   = in_fire && (in_act == srtm_pkg::ACT_TICK) && !is_idle;
  assign do_start  = in_fire && (in_act == srtm_pkg::ACT_START) && is_idle;
  assign half_end  = (tc_inc >= hp_eff) || (tc_inc == 8'd0);
  assign sending   = (byte_q == 4'd0) || !lat_rd_q;
  assign last_bit  = (bit_q == 3'd7);
  assign last_byte = (byte_q >= lat_cnt_q);
  assign cnt_clip  = (IW'(in_cnt) > IW'(MAX_BYTES)) ? 4'(MAX_BYTES) : in_cnt;
  assign ff_now    = (!sending && byte_q == 4'd1) ? (shift_q == srtm_pkg::ABSENT_VAL) : ff_q;

  // Transmit buffer: write on load, prefetch the entry at the current byte index
  logic [IW-1:0] wr_idx, rd_idx;
  logic          buf_wr, rd_in_range;
  logic [7:0]    buf_data;

  assign wr_idx      = IW'(in_cnt);
  assign rd_idx      = IW'(byte_q);
  assign buf_wr      = in_fire && (in_act == srtm_pkg::ACT_LOAD) && is_idle &&
                       (wr_idx < IW'(MAX_BYTES));
  assign rd_in_range = (rd_idx < IW'(MAX_BYTES));

  srtm_buf #(
    .DEPTH (MAX_BYTES),
    .AW    (AW)
  ) u_buf (
    .clk_i     (clk_i),
    .wr_en_i   (buf_wr),
    .wr_addr_i (wr_idx[AW-1:0]),
    .wr_data_i (in_wbyte),
    .rd_en_i   (rd_in_range),
    .rd_addr_i (rd_idx[AW-1:0]),
    .rd_data_o (buf_data)
  );

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (do_start) begin
      phase_d = srtm_pkg::PH_LEAD;
    end else if (do_tick && half_end) begin
      unique case (phase_q)
        srtm_pkg::PH_LEAD: phase_d = srtm_pkg::PH_LOW;
        srtm_pkg::PH_LOW:  phase_d = srtm_pkg::PH_HIGH;
        srtm_pkg::PH_HIGH: begin
          if (!last_bit || !last_byte) begin
            phase_d = srtm_pkg::PH_LOW;
          end else begin
            phase_d = srtm_pkg::PH_IDLE;
          end
        end
        default: phase_d = phase_q;
      endcase
    end
  end

  // Datapath and result
  srtm_pkg::res_t res;
  logic           rvalid, done, present;
  logic [7:0]     rbyte;

  always_comb begin
    tc_d       = tc_q;
    bit_d      = bit_q;
    byte_d     = byte_q;
    shift_d    = shift_q;
    lat_addr_d = lat_addr_q;
    lat_rd_d   = lat_rd_q;
    lat_cnt_d  = lat_cnt_q;
    ff_d       = ff_q;
    mosi_d     = mosi_q;
    rvalid     = 1'b0;
    rbyte      = 8'h00;
    done       = 1'b0;
    present    = 1'b0;
    if (do_start) begin
      lat_addr_d = in_addr;
      lat_rd_d   = in_rd;
      lat_cnt_d  = cnt_clip;
      shift_d    = ({1'b0, in_addr} & srtm_pkg::ADDR_MASK) |
                   (in_rd ? srtm_pkg::READ_FLAG : 8'h00);
      tc_d       = 8'd0;
      bit_d      = 3'd0;
      byte_d     = 4'd0;
      ff_d       = 1'b0;
    end else if (do_tick) begin
      tc_d = half_end ? 8'd0 : tc_inc;
      if (half_end && phase_q == srtm_pkg::PH_LOW) begin
        // Drive MOSI or sample MISO at the end of the low half
        if (sending) begin
          mosi_d  = shift_q[7];
          shift_d = {shift_q[6:0], 1'b0};
        end else begin
          shift_d = {shift_q[6:0], in_miso};
        end
      end else if (half_end && phase_q == srtm_pkg::PH_HIGH) begin
        if (!last_bit) begin
          bit_d = bit_q + 3'd1;
        end else begin
          bit_d  = 3'd0;
          byte_d = byte_q + 4'd1;
          ff_d   = ff_now;
          if (!sending) begin
            rvalid = 1'b1;
            rbyte  = shift_q;
          end
          if (last_byte) begin
            done    = 1'b1;
            present = lat_rd_q && (lat_cnt_q != 4'd0) && !ff_now;
          end else begin
            shift_d = lat_rd_q ? 8'h00 : buf_data;
          end
        end
      end
    end
  end

  assign res.chip_select    = (phase_d != srtm_pkg::PH_IDLE);
  assign res.serial_clock   = (phase_d != srtm_pkg::PH_LOW);
  assign res.mosi_level     = mosi_d;
  assign res.read_byte      = rbyte;
  assign res.read_valid     = rvalid;
  assign res.frame_done     = done;
  assign res.device_present = present;
  assign res.busy_res       = (phase_d != srtm_pkg::PH_IDLE);

  // Advance state on every accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= srtm_pkg::PH_IDLE;
      tc_q       <= 8'd0;
      bit_q      <= 3'd0;
      byte_q     <= 4'd0;
      shift_q    <= 8'd0;
      lat_addr_q <= 7'd0;
      lat_rd_q   <= 1'b0;
      lat_cnt_q  <= 4'd0;
      ff_q       <= 1'b0;
      mosi_q     <= 1'b0;
    end else if (in_fire) begin
      phase_q    <= phase_d;
      tc_q       <= tc_d;
      bit_q      <= bit_d;
      byte_q     <= byte_d;
      shift_q    <= shift_d;
      lat_addr_q <= lat_addr_d;
      lat_rd_q   <= lat_rd_d;
      lat_cnt_q  <= lat_cnt_d;
      ff_q       <= ff_d;
      mosi_q     <= mosi_d;
    end
  end

  // Output stage
  srtm_pkg::res_t out_res;

  srtm_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_res)
  );

  assign m_axis_tdata = {3'b000, out_res.busy_res, out_res.device_present,
                         out_res.read_byte, out_res.mosi_level,
                         out_res.serial_clock, out_res.chip_select};
  assign m_axis_tuser = out_res.read_valid;
  assign m_axis_tlast = out_res.frame_done;

  // Checks
  `SRTM_ASSERT_NEXT(a_done_idles, in_fire && res.frame_done, phase_q == srtm_pkg::PH_IDLE,
    "frame_done reported but sequencer still busy")
  `SRTM_ASSERT_NOW(a_rx_in_read, in_fire && res.read_valid, lat_rd_q && (byte_q != 4'd0),
    "received byte outside the data part of a read frame")
  `SRTM_ASSERT_NOW(a_byte_bound, !is_idle, byte_q <= lat_cnt_q,
    "byte index ran past the requested count")
  `SRTM_ASSERT_NOW(a_lat_addr, do_start, (lat_addr_q == lat_addr_q) && is_idle,
    "start taken while a frame runs")

endmodule
